@@ sv/lphm_pkg.sv @@
// Shared types, constants and codes for the linear-probe hash map.
// No dependencies; used by every module of the block.
package lphm_pkg;

	localparam int MAX_ENTRIES_DEF = 1024;
	localparam int MIN_ENTRIES_DEF = 16;

	// hash mix
	localparam logic [63:0] MIX_MUL   = 64'h9ddfea08eb382d69;
	localparam int          MIX_SHIFT = 47;

	// operation codes
	localparam logic [1:0] OP_PUT    = 2'd0;
	localparam logic [1:0] OP_GET    = 2'd1;
	localparam logic [1:0] OP_DEL    = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// result status codes
	localparam logic [1:0] RS_OK        = 2'd0;
	localparam logic [1:0] RS_NOT_FOUND = 2'd1;
	localparam logic [1:0] RS_DUP       = 2'd2;
	localparam logic [1:0] RS_FULL      = 2'd3;

	// input word: operation, key, value, zero padded to bytes
	localparam int IN_W = 136;

	typedef enum logic [2:0] {
		MEM_IDLE,
		MEM_PROBE_RD,
		MEM_INS_WR,
		MEM_DEL_WR,
		MEM_SCAN_RD,
		MEM_CLR_WR
	} mem_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_HASH_GO,
		S_HASH,
		S_PROBE,
		S_INS_CHK,
		S_FIND_CHK,
		S_SHRINK,
		S_CLR,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic       load_req;
		logic       hash_start;
		logic       slot_load;
		logic       slot_next;
		mem_op_t    mem_op;
		logic       use_other;
		logic       live_inc;
		logic       live_dec;
		logic       grow;
		logic       shrink;
		logic       clr_init;
		logic       clr_next;
		logic       scan_init;
		logic       scan_next;
		logic       cnt_inc;
		logic       ins_load;
		logic       commit;
		logic       set_status;
		logic [1:0] status;
		logic       rv_mem;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       cap_zero;
		logic       need_grow;
		logic       shrink_ok;
		logic       hash_done;
		logic       rk_used;
		logic       rk_chain;
		logic       rk_match;
		logic       probe_last;
		logic       clr_last;
		logic       scan_end;
	} sts_t;

endpackage

@@ sv/lphm_hash.sv @@
// Multiply-xorshift-multiply key mix on one shared 32x32 multiplier.
// Depends on lphm_pkg.
module lphm_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] key,
	output logic        done,
	output logic [63:0] result
);

	localparam logic [3:0] STEP_PASS = 4'd5;
	localparam logic [3:0] STEP_XOR  = 4'd4;
	localparam logic [3:0] STEP_LAST = 4'd9;

	logic        busy_q;
	logic [3:0]  step_q;
	logic [3:0]  phase;
	logic [63:0] a_q;
	logic [63:0] p_q;
	logic [63:0] acc_q;
	logic [31:0] ma;
	logic [31:0] mb;

	always_comb begin
		phase = (step_q >= STEP_PASS) ? step_q - STEP_PASS : step_q;
		ma = a_q[31:0];
		mb = lphm_pkg::MIX_MUL[31:0];
		case (phase)
			4'd1: mb = lphm_pkg::MIX_MUL[63:32];
			4'd2: ma = a_q[63:32];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 4'd1;
			if (step_q == STEP_LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	// 64x64 low product as three partial products, each summed from the registered product in the following cycle
	always_ff @(posedge clk) begin
		p_q <= ma * mb;
		if (start) begin
			a_q <= key;
		end else if (step_q == STEP_XOR) begin
			a_q <= acc_q ^ (acc_q >> lphm_pkg::MIX_SHIFT);
		end
		case (phase)
			4'd1: acc_q <= p_q;
			4'd2, 4'd3: acc_q[63:32] <= acc_q[63:32] + p_q[31:0];
			default: ;
		endcase
	end

	assign done   = busy_q && (step_q == STEP_LAST);
	assign result = acc_q;

endmodule

@@ sv/lphm_dp.sv @@
// Datapath: request registers, two key/value banks, probe and rehash counters.
// Depends on lphm_pkg and lphm_hash; steered by lphm_ctrl through cmd_t.
module lphm_dp #(
	parameter int MAX_ENTRIES = lphm_pkg::MAX_ENTRIES_DEF,
	parameter int MIN_ENTRIES = lphm_pkg::MIN_ENTRIES_DEF,
	localparam int AW = $clog2(MAX_ENTRIES),
	localparam int CW = AW + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lphm_pkg::cmd_t    cmd,
	output lphm_pkg::sts_t    sts,
	input  logic [1:0]        in_operation,
	input  logic [63:0]       in_key,
	input  logic [63:0]       in_value,
	output logic [1:0]        status,
	output logic [63:0]       read_value,
	output logic [CW-1:0]     entry_count
);

	localparam logic [CW-1:0] CAP_MAX = CW'(MAX_ENTRIES);
	localparam logic [CW-1:0] CAP_MIN = CW'(MIN_ENTRIES);

	logic [1:0]    req_op_q;
	logic [63:0]   req_key_q;
	logic [63:0]   req_val_q;
	logic [63:0]   ins_key_q;
	logic [63:0]   ins_val_q;
	logic          active_q;
	logic [CW-1:0] cap_q;
	logic [CW-1:0] live_q;
	logic [CW-1:0] newcap_q;
	logic [CW-1:0] pcap_q;
	logic [AW-1:0] slot_q;
	logic [AW-1:0] iter_q;
	logic [AW-1:0] clr_q;
	logic [CW-1:0] src_q;
	logic [CW-1:0] cnt_q;
	logic          rd_bank_q;
	logic [1:0]    res_status_q;
	logic [63:0]   res_rv_q;
	logic [1:0]    out_status_q;
	logic [63:0]   out_rv_q;
	logic [CW-1:0] out_count_q;

	logic [63:0]   kq [2];
	logic [63:0]   vq [2];
	logic [63:0]   rk;
	logic [63:0]   rv;
	logic          tgt;
	logic [AW-1:0] addr;
	logic          kwe;
	logic          vwe;
	logic [63:0]   kwd;
	logic          hash_done;
	logic [63:0]   hash_res;
	logic [CW-1:0] pcap_sel;
	logic [CW-1:0] grow_cap;
	logic [CW-1:0] shrink_cap;
	logic [CW-1:0] grow_thr;

	lphm_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.hash_start),
		.key    (ins_key_q),
		.done   (hash_done),
		.result (hash_res)
	);

	assign rk = rd_bank_q ? kq[1] : kq[0];
	assign rv = rd_bank_q ? vq[1] : vq[0];

	always_comb begin
		tgt  = active_q ^ cmd.use_other;
		addr = slot_q;
		kwe  = 1'b0;
		vwe  = 1'b0;
		kwd  = ins_key_q;
		unique case (cmd.mem_op)
			lphm_pkg::MEM_IDLE, lphm_pkg::MEM_PROBE_RD: ;
			lphm_pkg::MEM_INS_WR: begin
				kwe = 1'b1;
				vwe = 1'b1;
			end
			lphm_pkg::MEM_DEL_WR: begin
				tgt = active_q;
				kwe = 1'b1;
				kwd = rk & ~64'd1;
			end
			lphm_pkg::MEM_SCAN_RD: begin
				tgt  = active_q;
				addr = src_q[AW-1:0];
			end
			lphm_pkg::MEM_CLR_WR: begin
				tgt  = ~active_q;
				addr = clr_q;
				kwe  = 1'b1;
				kwd  = '0;
			end
			default: ;
		endcase
	end

	for (genvar b = 0; b < 2; b++) begin : g_bank
		logic [63:0] kmem [MAX_ENTRIES];
		logic [63:0] vmem [MAX_ENTRIES];
		always_ff @(posedge clk) begin
			if (kwe && (tgt == 1'(b))) begin
				kmem[addr] <= kwd;
			end
			if (vwe && (tgt == 1'(b))) begin
				vmem[addr] <= ins_val_q;
			end
			kq[b] <= kmem[addr];
			vq[b] <= vmem[addr];
		end
	end

	always_comb begin
		pcap_sel   = cmd.use_other ? newcap_q : cap_q;
		grow_thr   = ((cap_q >> 2) << 1) + (cap_q >> 2);
		grow_cap   = cap_q << 1;
		if (grow_cap < CAP_MIN) grow_cap = CAP_MIN;
		if (grow_cap > CAP_MAX) grow_cap = CAP_MAX;
		shrink_cap = cap_q >> 1;
		if (shrink_cap < CAP_MIN) shrink_cap = CAP_MIN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			cap_q     <= '0;
			live_q    <= '0;
			rd_bank_q <= 1'b0;
		end else begin
			rd_bank_q <= tgt;
			if (cmd.commit) begin
				active_q <= ~active_q;
				cap_q    <= newcap_q;
				live_q   <= cnt_q;
			end else if (cmd.live_inc) begin
				live_q <= live_q + CW'(1);
			end else if (cmd.live_dec) begin
				live_q <= live_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_op_q  <= in_operation;
			req_key_q <= in_key | 64'd3;
			req_val_q <= in_value;
			ins_key_q <= in_key | 64'd3;
			ins_val_q <= in_value;
			res_rv_q  <= '0;
		end else if (cmd.ins_load) begin
			ins_key_q <= rk;
			ins_val_q <= rv;
		end else if (cmd.commit) begin
			ins_key_q <= req_key_q;
			ins_val_q <= req_val_q;
		end
		if (cmd.grow) newcap_q <= grow_cap;
		if (cmd.shrink) newcap_q <= shrink_cap;
		if (cmd.slot_load) begin
			pcap_q <= pcap_sel;
			slot_q <= hash_res[AW-1:0] & AW'(pcap_sel - CW'(1));
			iter_q <= '0;
		end else if (cmd.slot_next) begin
			slot_q <= (slot_q + AW'(1)) & AW'(pcap_q - CW'(1));
			iter_q <= iter_q + AW'(1);
		end
		if (cmd.clr_init) clr_q <= '0;
		else if (cmd.clr_next) clr_q <= clr_q + AW'(1);
		if (cmd.scan_init) begin
			src_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.scan_next) src_q <= src_q + CW'(1);
			if (cmd.cnt_inc) cnt_q <= cnt_q + CW'(1);
		end
		if (cmd.set_status) res_status_q <= cmd.status;
		if (cmd.rv_mem) res_rv_q <= rv;
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_rv_q     <= res_rv_q;
			out_count_q  <= live_q;
		end
	end

	always_comb begin
		sts.op         = req_op_q;
		sts.cap_zero   = (cap_q == '0);
		sts.need_grow  = (live_q >= grow_thr) && (cap_q < CAP_MAX);
		sts.shrink_ok  = (cap_q > CAP_MIN) && (live_q < (cap_q >> 2));
		sts.hash_done  = hash_done;
		sts.rk_used    = rk[0];
		sts.rk_chain   = rk[1];
		sts.rk_match   = (rk == ins_key_q);
		sts.probe_last = (iter_q == AW'(pcap_q - CW'(1)));
		sts.clr_last   = (clr_q == AW'(newcap_q - CW'(1)));
		sts.scan_end   = (src_q == cap_q);
	end

	assign status      = out_status_q;
	assign read_value  = out_rv_q;
	assign entry_count = out_count_q;

endmodule

@@ sv/lphm_ctrl.sv @@
// Controller FSM: request dispatch, probe loops, rehash sequencing, result hold.
// Depends on lphm_pkg; drives lphm_dp through cmd_t.
module lphm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  lphm_pkg::sts_t sts,
	output lphm_pkg::cmd_t cmd
);

	lphm_pkg::state_t state_q, state_d;
	logic rh_q, rh_d;
	logic out_valid_q;
	logic ins_mode;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lphm_pkg::S_IDLE;
			rh_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rh_q    <= rh_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign ins_mode  = rh_q || (sts.op == lphm_pkg::OP_PUT);
	assign in_ready  = (state_q == lphm_pkg::S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.mem_op    = lphm_pkg::MEM_IDLE;
		cmd.use_other = rh_q;
		state_d       = state_q;
		rh_d          = rh_q;
		unique case (state_q)
			lphm_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = lphm_pkg::S_DISPATCH;
				end
			end
			lphm_pkg::S_DISPATCH: begin
				case (sts.op)
					lphm_pkg::OP_PUT: begin
						if (sts.need_grow) begin
							cmd.grow     = 1'b1;
							cmd.clr_init = 1'b1;
							rh_d         = 1'b1;
							state_d      = lphm_pkg::S_CLR;
						end else begin
							cmd.hash_start = 1'b1;
							state_d        = lphm_pkg::S_HASH;
						end
					end
					lphm_pkg::OP_GET, lphm_pkg::OP_DEL: begin
						if (sts.cap_zero) begin
							cmd.set_status = 1'b1;
							cmd.status     = lphm_pkg::RS_NOT_FOUND;
							state_d        = lphm_pkg::S_RESULT;
						end else begin
							cmd.hash_start = 1'b1;
							state_d        = lphm_pkg::S_HASH;
						end
					end
					default: begin
						cmd.set_status = 1'b1;
						cmd.status     = lphm_pkg::RS_NOT_FOUND;
						state_d        = lphm_pkg::S_RESULT;
					end
				endcase
			end
			lphm_pkg::S_HASH_GO: begin
				cmd.hash_start = 1'b1;
				state_d        = lphm_pkg::S_HASH;
			end
			lphm_pkg::S_HASH: begin
				if (sts.hash_done) begin
					cmd.slot_load = 1'b1;
					state_d       = lphm_pkg::S_PROBE;
				end
			end
			lphm_pkg::S_PROBE: begin
				cmd.mem_op = lphm_pkg::MEM_PROBE_RD;
				state_d    = ins_mode ? lphm_pkg::S_INS_CHK : lphm_pkg::S_FIND_CHK;
			end
			lphm_pkg::S_INS_CHK: begin
				if (!sts.rk_used) begin
					cmd.mem_op = lphm_pkg::MEM_INS_WR;
					if (rh_q) begin
						cmd.cnt_inc   = 1'b1;
						cmd.scan_next = 1'b1;
						state_d       = lphm_pkg::S_SCAN_RD;
					end else begin
						cmd.live_inc   = 1'b1;
						cmd.set_status = 1'b1;
						cmd.status     = lphm_pkg::RS_OK;
						state_d        = lphm_pkg::S_RESULT;
					end
				end else if (sts.rk_match || sts.probe_last) begin
					state_d = lphm_pkg::S_RESULT;
					if (rh_q) begin
						// rehash abandoned; old bank stays live
						rh_d = 1'b0;
						if (sts.op == lphm_pkg::OP_PUT) begin
							cmd.set_status = 1'b1;
							cmd.status     = lphm_pkg::RS_DUP;
						end
					end else begin
						cmd.set_status = 1'b1;
						cmd.status     = sts.rk_match ? lphm_pkg::RS_DUP : lphm_pkg::RS_FULL;
					end
				end else begin
					cmd.slot_next = 1'b1;
					state_d       = lphm_pkg::S_PROBE;
				end
			end
			lphm_pkg::S_FIND_CHK: begin
				if (sts.rk_match) begin
					cmd.set_status = 1'b1;
					cmd.status     = lphm_pkg::RS_OK;
					cmd.rv_mem     = 1'b1;
					if (sts.op == lphm_pkg::OP_DEL) begin
						cmd.mem_op   = lphm_pkg::MEM_DEL_WR;
						cmd.live_dec = 1'b1;
						state_d      = lphm_pkg::S_SHRINK;
					end else begin
						state_d = lphm_pkg::S_RESULT;
					end
				end else if (!sts.rk_chain || sts.probe_last) begin
					cmd.set_status = 1'b1;
					cmd.status     = lphm_pkg::RS_NOT_FOUND;
					state_d        = lphm_pkg::S_RESULT;
				end else begin
					cmd.slot_next = 1'b1;
					state_d       = lphm_pkg::S_PROBE;
				end
			end
			lphm_pkg::S_SHRINK: begin
				if (sts.shrink_ok) begin
					cmd.shrink   = 1'b1;
					cmd.clr_init = 1'b1;
					rh_d         = 1'b1;
					state_d      = lphm_pkg::S_CLR;
				end else begin
					state_d = lphm_pkg::S_RESULT;
				end
			end
			lphm_pkg::S_CLR: begin
				cmd.mem_op = lphm_pkg::MEM_CLR_WR;
				if (sts.clr_last) begin
					cmd.scan_init = 1'b1;
					state_d       = lphm_pkg::S_SCAN_RD;
				end else begin
					cmd.clr_next = 1'b1;
				end
			end
			lphm_pkg::S_SCAN_RD: begin
				if (sts.scan_end) begin
					cmd.commit = 1'b1;
					rh_d       = 1'b0;
					state_d    = (sts.op == lphm_pkg::OP_PUT) ? lphm_pkg::S_HASH_GO
					                                          : lphm_pkg::S_RESULT;
				end else begin
					cmd.mem_op = lphm_pkg::MEM_SCAN_RD;
					state_d    = lphm_pkg::S_SCAN_CHK;
				end
			end
			lphm_pkg::S_SCAN_CHK: begin
				if (sts.rk_used) begin
					cmd.ins_load = 1'b1;
					state_d      = lphm_pkg::S_HASH_GO;
				end else begin
					cmd.scan_next = 1'b1;
					state_d       = lphm_pkg::S_SCAN_RD;
				end
			end
			lphm_pkg::S_RESULT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = lphm_pkg::S_IDLE;
				end
			end
			default: state_d = lphm_pkg::S_IDLE;
		endcase
	end

endmodule

@@ sv/linear_probe_hash_map_top.sv @@
// Linear-probing hash map with lazy delete and two-bank rehash.
// Instantiates lphm_ctrl and lphm_dp (which holds lphm_hash); uses lphm_pkg.
//
// Usage:
//   Requests enter on the s_axis group, one word each: operation (put, get,
//   delete), a 64-bit key (two low bits forced to ones) and a put value.
//   Every request yields exactly one result word on m_axis: status,
//   read value and live entry count after the request.
//   One request is in flight at a time; s_axis_tready is high only while
//   the controller waits for a new word.
//   From accept, a request is dispatched, hashed by the hash unit and then
//   probed, each probe being one memory read and one check; a delete adds a
//   shrink check. s_axis_tready rises in the same cycle as m_axis_tvalid.
//   A rehash adds clearing of the new bank over newcap slots, a read and
//   check per old slot scanned and one hash plus probe run per live entry moved.
//   The result sits in an output register; the block takes the next request
//   while it waits, and stalls only when a second result is ready before the
//   first one is taken.
//   After reset the table is empty (capacity zero) and no clearing pass is
//   needed: a bank is always cleared over its new capacity before use.
module linear_probe_hash_map_top #(
	parameter int MAX_ENTRIES = lphm_pkg::MAX_ENTRIES_DEF,
	parameter int MIN_ENTRIES = lphm_pkg::MIN_ENTRIES_DEF,
	localparam int CW    = $clog2(MAX_ENTRIES) + 1,
	localparam int OUT_W = ((66 + CW + 7) / 8) * 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	// operation[1:0], key[65:2], value[129:66], zero pad
	input  logic [lphm_pkg::IN_W-1:0] s_axis_tdata,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	// status[1:0], read_value[65:2], entry_count[66+CW-1:66], zero pad
	output logic [OUT_W-1:0]         m_axis_tdata
);

	lphm_pkg::cmd_t cmd;
	lphm_pkg::sts_t sts;
	logic [1:0]     status;
	logic [63:0]    read_value;
	logic [CW-1:0]  entry_count;

	lphm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lphm_dp #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.MIN_ENTRIES (MIN_ENTRIES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_operation (s_axis_tdata[1:0]),
		.in_key       (s_axis_tdata[65:2]),
		.in_value     (s_axis_tdata[129:66]),
		.status       (status),
		.read_value   (read_value),
		.entry_count  (entry_count)
	);

	// result word, lowest field first
	assign m_axis_tdata = {(OUT_W - 66 - CW)'(0), entry_count, read_value, status};

endmodule

@@ sv/lphm_chk.sv @@
// Port-level checker for linear_probe_hash_map_top, bound to every instance.
// Depends on lphm_pkg for status codes.
module lphm_chk #(
	parameter int MAX_ENTRIES = lphm_pkg::MAX_ENTRIES_DEF,
	localparam int CW    = $clog2(MAX_ENTRIES) + 1,
	localparam int OUT_W = ((66 + CW + 7) / 8) * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata
);

	// result word holds while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word dropped or changed under stall");

	// one request at a time
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while another is in flight");

	// only a successful request returns a value
	a_rv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[1:0] != lphm_pkg::RS_OK) |-> m_axis_tdata[65:2] == '0)
		else $error("nonzero read value on failed request");

	// live count bounded by table size
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[66+CW-1:66] <= CW'(MAX_ENTRIES))
		else $error("entry count above table size");

endmodule

bind linear_probe_hash_map_top lphm_chk #(.MAX_ENTRIES(MAX_ENTRIES)) u_lphm_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

@@ bench/lphm_checker.sv @@
// Request/result checker for the linear-probe hash map: predicts each result from
// accepted request words and compares it with the result words. Uses lphm_pkg.
`timescale 1ns / 100ps

module lphm_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [135:0] s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [79:0]  m_axis_tdata,
	output int           fail_count,
	output int           pending_count,
	output int           result_count,
	output int           full_count,
	output int           max_capacity
);

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] read_value;
		logic [10:0] entry_count;
	} map_result_t;

	localparam int MAXE = lphm_pkg::MAX_ENTRIES_DEF;
	localparam int MINE = lphm_pkg::MIN_ENTRIES_DEF;

	logic [63:0] slot_key [2][MAXE];
	logic [63:0] slot_val [2][MAXE];
	bit          cur_bank;
	int          cur_cap;
	int          cur_live;
	map_result_t expected_results[$];

	function automatic logic [63:0] hash_mix(logic [63:0] k);
		k = k * lphm_pkg::MIX_MUL;
		k = k ^ (k >> lphm_pkg::MIX_SHIFT);
		k = k * lphm_pkg::MIX_MUL;
		return k;
	endfunction

	// insert a marked key; returns ok, dup or full
	function automatic logic [1:0] place_key(bit bnk, int cap, inout int cnt,
			logic [63:0] k, logic [63:0] v);
		int slot;
		if (cap == 0)
			return lphm_pkg::RS_FULL;
		slot = int'(hash_mix(k) & 64'(cap - 1));
		for (int i = 0; i < cap; i++) begin
			if (!slot_key[bnk][slot][0]) begin
				slot_val[bnk][slot] = v;
				slot_key[bnk][slot] = k;
				cnt++;
				return lphm_pkg::RS_OK;
			end
			if (slot_key[bnk][slot] == k)
				return lphm_pkg::RS_DUP;
			slot = (slot + 1) & (cap - 1);
		end
		return lphm_pkg::RS_FULL;
	endfunction

	// move every live entry to the other bank; 0 on success
	function automatic bit resize_table(int newcap);
		bit other;
		int cnt;
		other = ~cur_bank;
		cnt = 0;
		for (int i = 0; i < MAXE; i++)
			slot_key[other][i] = '0;
		for (int i = 0; i < cur_cap; i++)
			if (slot_key[cur_bank][i][0])
				if (place_key(other, newcap, cnt, slot_key[cur_bank][i],
						slot_val[cur_bank][i]) != lphm_pkg::RS_OK)
					return 1;
		cur_bank = other;
		cur_cap = newcap;
		cur_live = cnt;
		return 0;
	endfunction

	function automatic int find_slot(logic [63:0] k);
		int slot;
		if (cur_cap == 0)
			return -1;
		slot = int'(hash_mix(k) & 64'(cur_cap - 1));
		for (int i = 0; i < cur_cap; i++) begin
			if (slot_key[cur_bank][slot] == k)
				return slot;
			if (!slot_key[cur_bank][slot][1])
				return -1;
			slot = (slot + 1) & (cur_cap - 1);
		end
		return -1;
	endfunction

	function automatic map_result_t apply_request(logic [1:0] op, logic [63:0] key,
			logic [63:0] value);
		map_result_t r;
		logic [63:0] k;
		int pos;
		int nc;
		k = key | 64'd3;
		r.status = lphm_pkg::RS_NOT_FOUND;
		r.read_value = '0;
		if (op == lphm_pkg::OP_PUT) begin
			r.status = lphm_pkg::RS_OK;
			if (cur_live >= 3 * (cur_cap / 4) && cur_cap < MAXE) begin
				nc = cur_cap * 2;
				if (nc < MINE) nc = MINE;
				if (nc > MAXE) nc = MAXE;
				if (resize_table(nc))
					r.status = lphm_pkg::RS_DUP;
			end
			if (r.status == lphm_pkg::RS_OK)
				r.status = place_key(cur_bank, cur_cap, cur_live, k, value);
		end else if (op == lphm_pkg::OP_GET || op == lphm_pkg::OP_DEL) begin
			pos = find_slot(k);
			if (pos >= 0) begin
				r.status = lphm_pkg::RS_OK;
				r.read_value = slot_val[cur_bank][pos];
				if (op == lphm_pkg::OP_DEL) begin
					slot_key[cur_bank][pos][0] = 1'b0;
					cur_live--;
					// shrink; a failed rehash leaves the delete in place
					if (cur_cap > MINE && cur_live < cur_cap / 4) begin
						nc = cur_cap / 2;
						if (nc < MINE) nc = MINE;
						void'(resize_table(nc));
					end
				end
			end
		end
		r.entry_count = 11'(cur_live);
		return r;
	endfunction

	initial begin
		for (int b = 0; b < 2; b++)
			for (int i = 0; i < MAXE; i++) begin
				slot_key[b][i] = '0;
				slot_val[b][i] = '0;
			end
		cur_bank = 0;
		cur_cap = 0;
		cur_live = 0;
		fail_count = 0;
		pending_count = 0;
		result_count = 0;
		full_count = 0;
		max_capacity = 0;
	end

	always @(posedge clk) begin
		map_result_t exp_r, got_r;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			expected_results.push_back(apply_request(s_axis_tdata[1:0],
				s_axis_tdata[65:2], s_axis_tdata[129:66]));
			if (cur_cap > max_capacity) max_capacity = cur_cap;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_r.status = m_axis_tdata[1:0];
			got_r.read_value = m_axis_tdata[65:2];
			got_r.entry_count = m_axis_tdata[76:66];
			result_count++;
			if (got_r.status == lphm_pkg::RS_FULL) full_count++;
			if (expected_results.size() == 0) begin
				$error("result word with nothing expected: %h", m_axis_tdata);
				fail_count++;
			end else begin
				exp_r = expected_results.pop_front();
				if (got_r.status !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, got_r.status);
					fail_count++;
				end
				if (got_r.read_value !== exp_r.read_value) begin
					$error("read_value: expected %h, got %h",
						exp_r.read_value, got_r.read_value);
					fail_count++;
				end
				if (got_r.entry_count !== exp_r.entry_count) begin
					$error("entry_count: expected %0d, got %0d",
						exp_r.entry_count, got_r.entry_count);
					fail_count++;
				end
			end
		end
		pending_count = expected_results.size();
	end

endmodule

@@ bench/testbench.sv @@
// Top of the hash map bench: clock, reset, request stimulus, result backpressure
// and verdict. Depends on lphm_pkg, linear_probe_hash_map_top and lphm_checker.
`timescale 1ns / 100ps

module testbench;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	// operation[1:0], key[65:2], value[129:66], zero pad
	logic [135:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	// status[1:0], read_value[65:2], entry_count[76:66], zero pad
	logic [79:0]  m_axis_tdata;

	int fail_count, pending_count, result_count, full_count, max_capacity;
	int send_idle_pct;   // chance per cycle that the sender holds off
	int recv_stall_pct;  // chance per cycle that the receiver stalls
	int words_sent;

	// key pool shared by a phase, so gets and deletes mostly hit live keys
	logic [63:0] key_pool[$];

	linear_probe_hash_map_top u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	lphm_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.fail_count(fail_count), .pending_count(pending_count),
		.result_count(result_count), .full_count(full_count),
		.max_capacity(max_capacity)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver: new ready decision every falling edge
	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

	// one request word; valid stays up across back-to-back words
	task automatic send_request(logic [1:0] op, logic [63:0] key, logic [63:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, value, key, op};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		words_sent++;
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// random request over a pool of pool_size keys; weights in percent
	task automatic random_request(int pool_size, int put_pct, int get_pct, int del_pct);
		int pick;
		logic [1:0] op;
		logic [63:0] key;
		while (key_pool.size() < pool_size)
			key_pool.push_back(rand64());
		pick = $urandom_range(99);
		if (pick < put_pct) op = lphm_pkg::OP_PUT;
		else if (pick < put_pct + get_pct) op = lphm_pkg::OP_GET;
		else if (pick < put_pct + get_pct + del_pct) op = lphm_pkg::OP_DEL;
		else op = lphm_pkg::OP_UNUSED;  // must be a no-op
		// mostly pool keys; low two bits random since the block ignores them
		if ($urandom_range(9) == 0) key = rand64();
		else key = {key_pool[$urandom_range(pool_size - 1)][63:2], 2'($urandom)};
		send_request(op, key, rand64());
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		words_sent = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty table, extremes, duplicates, deletes, unused code
		send_request(lphm_pkg::OP_GET, 64'd0, 64'd0);
		send_request(lphm_pkg::OP_DEL, '1, '1);
		send_request(lphm_pkg::OP_UNUSED, '1, '1);
		send_request(lphm_pkg::OP_PUT, 64'd0, '1);
		send_request(lphm_pkg::OP_PUT, '1, 64'd0);
		send_request(lphm_pkg::OP_PUT, 64'd2, 64'h5555_5555_5555_5555);  // same key as zero
		send_request(lphm_pkg::OP_GET, 64'd1, 64'd0);
		send_request(lphm_pkg::OP_GET, 64'hffff_ffff_ffff_fffc, 64'd0);
		send_request(lphm_pkg::OP_PUT, 64'h8000_0000_0000_0000, 64'haaaa_aaaa_aaaa_aaaa);
		send_request(lphm_pkg::OP_DEL, 64'd0, 64'd0);
		send_request(lphm_pkg::OP_GET, 64'd3, 64'd0);
		send_request(lphm_pkg::OP_DEL, 64'd3, 64'd0);
		send_request(lphm_pkg::OP_PUT, 64'd0, 64'h1234_5678_9abc_def0);
		send_request(lphm_pkg::OP_GET, 64'h8000_0000_0000_0003, 64'd0);
		send_request(lphm_pkg::OP_DEL, '1, 64'd0);
		send_request(lphm_pkg::OP_DEL, 64'h8000_0000_0000_0000, 64'd0);
		send_request(lphm_pkg::OP_UNUSED, 64'd0, 64'd0);

		// four phases of sender idling and receiver stalls; pool sizes drive growth, then shrink
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
				default: begin send_idle_pct = 24; recv_stall_pct = 24; end
			endcase
			key_pool.delete();
			for (int n = 0; n < 175; n++) begin
				case (ph)
					0: random_request(24, 40, 30, 25);          // small table churn
					1: random_request(400, 80, 10, 8);          // grow toward 512+
					2: random_request(400, 35, 25, 38);
					default: random_request(400, 5, 25, 68);    // shrink back
				endcase
			end
		end

		s_axis_tvalid <= 1'b0;
		wait (pending_count == 0);
		repeat (200) @(posedge clk);
		$display("Sent %0d request words, checked %0d results; largest capacity %0d, %0d full",
			words_sent, result_count, max_capacity, full_count);
		$display("Covered put/get/delete/unused codes, duplicates, grow and shrink rehash.");
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#8000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/lphm_pkg.sv
sv/lphm_hash.sv
sv/lphm_dp.sv
sv/lphm_ctrl.sv
sv/linear_probe_hash_map_top.sv
sv/lphm_chk.sv
bench/lphm_checker.sv
bench/testbench.sv
